@@ hdl/elliptic_curve_trace_mod_prime_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms; each expects clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ELLIPTIC_CURVE_TRACE_MOD_PRIME_DEFINES_SVH
`define ELLIPTIC_CURVE_TRACE_MOD_PRIME_DEFINES_SVH

// same-cycle implication
`define ECTMP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ECTMP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ectmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ectmp_pkg
// Widths, constants, beat types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ectmp_pkg;

	localparam int MOD_W   = 10;
	localparam int COEF_W  = 10;
	localparam int OP_W    = (MOD_W > COEF_W) ? MOD_W : COEF_W;
	localparam int CNT_W   = $clog2(OP_W + 1);
	localparam int SUM_W   = MOD_W + 2;
	localparam int CALC_W  = MOD_W + 12;
	localparam int TRACE_W = 8;
	localparam int ORDER_W = 11;

	localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(601);
	localparam logic [MOD_W-1:0] ONE           = MOD_W'(1);
	localparam logic [MOD_W-1:0] MIN_MODULUS   = MOD_W'(3);
	localparam logic [OP_W-1:0]  K_FOUR        = OP_W'(4);
	localparam logic [OP_W-1:0]  K_TWENTYSEVEN = OP_W'(27);

	localparam int TRACE_HI = 127;
	localparam int TRACE_LO = -128;
	localparam int ORDER_HI = 2047;

	typedef struct packed {
		logic [COEF_W-1:0] coef_a;
		logic [COEF_W-1:0] coef_b;
	} in_item_t;

	typedef struct packed {
		logic                      nonsingular;
		logic signed [TRACE_W-1:0] trace;
		logic [ORDER_W-1:0]        curve_order;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_RED_A = 4'd0,
		OP_RED_B = 4'd1,
		OP_A2    = 4'd2,
		OP_A3    = 4'd3,
		OP_A4    = 4'd4,
		OP_B2    = 4'd5,
		OP_B27   = 4'd6,
		OP_X2    = 4'd7,
		OP_X3    = 4'd8,
		OP_AX    = 4'd9,
		OP_PMUL  = 4'd10,
		OP_PSQ   = 4'd11
	} mul_op_t;

	typedef struct packed {
		logic    in_load;
		logic    mul_start;
		mul_op_t mul_op;
		logic    mul_wr;
		logic    set_sing;
		logic    init_loop;
		logic    form_f;
		logic    step_x;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic low_mod;
		logic disc_zero;
		logic f_zero;
		logic e_lsb;
		logic e_last;
		logic x_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ hdl/ectmp_modmul.sv @@
// ----------------------------------------------------------------------------
// ectmp_modmul
// Bit-serial interleaved modular multiplier, one bit of op1 per cycle.
// ----------------------------------------------------------------------------
`include "elliptic_curve_trace_mod_prime_defines.svh"

module ectmp_modmul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ectmp_pkg::OP_W-1:0]  op1,
	input  logic [ectmp_pkg::MOD_W-1:0] op2,
	input  logic [ectmp_pkg::MOD_W-1:0] p,
	output logic                        done,
	output logic [ectmp_pkg::MOD_W-1:0] res
);

	logic                         busy_q;
	logic                         done_q;
	logic [ectmp_pkg::CNT_W-1:0]  cnt_q;
	logic [ectmp_pkg::OP_W-1:0]   sh_q;
	logic [ectmp_pkg::MOD_W-1:0]  m_q;
	logic [ectmp_pkg::MOD_W-1:0]  acc_q;

	logic [ectmp_pkg::MOD_W+1:0]  dbl;
	logic [ectmp_pkg::MOD_W+1:0]  addend;
	logic [ectmp_pkg::MOD_W+1:0]  sum_t;
	logic [ectmp_pkg::MOD_W+1:0]  p1;
	logic [ectmp_pkg::MOD_W+1:0]  p2;
	logic [ectmp_pkg::MOD_W+1:0]  red;

	always_comb begin
		dbl    = {1'b0, acc_q, 1'b0};
		addend = sh_q[ectmp_pkg::OP_W-1] ? {2'b00, m_q} : '0;
		sum_t  = dbl + addend;
		p1     = {2'b00, p};
		p2     = {1'b0, p, 1'b0};
		if (sum_t >= p2) begin
			red = sum_t - p2;
		end else if (sum_t >= p1) begin
			red = sum_t - p1;
		end else begin
			red = sum_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == ectmp_pkg::CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ectmp_pkg::CNT_W'(ectmp_pkg::OP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ectmp_pkg::CNT_W'(1);
				if (cnt_q == ectmp_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= op1;
			m_q   <= op2;
			acc_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << 1;
			acc_q <= red[ectmp_pkg::MOD_W-1:0];
		end
	end

	assign done = done_q;
	assign res  = acc_q;

	`ECTMP_ASSERT_IMP(a_mm_idle_start, start, !busy_q, "multiplier started while busy")
	`ECTMP_ASSERT_IMP(a_mm_reduced, done_q, acc_q < p, "product not reduced below modulus")
	`ECTMP_ASSERT_NXT(a_mm_last, busy_q && (cnt_q == ectmp_pkg::CNT_W'(1)), done_q && !busy_q, "last bit not followed by done")

endmodule

@@ hdl/ectmp_dp.sv @@
// ----------------------------------------------------------------------------
// ectmp_dp
// Datapath: modulus register, operand registers, shared multiplier,
// Legendre sum and output register.
// ----------------------------------------------------------------------------
module ectmp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr,
	input  logic [ectmp_pkg::MOD_W-1:0] cfg_data,
	input  ectmp_pkg::in_item_t         in_data,
	input  ectmp_pkg::dp_cmd_t          cmd,
	output ectmp_pkg::dp_stat_t         st,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ectmp_pkg::out_item_t        out_data
);

	localparam logic signed [ectmp_pkg::CALC_W-1:0] TR_HI  =
		ectmp_pkg::CALC_W'(ectmp_pkg::TRACE_HI);
	localparam logic signed [ectmp_pkg::CALC_W-1:0] TR_LO  =
		ectmp_pkg::CALC_W'(ectmp_pkg::TRACE_LO);
	localparam logic signed [ectmp_pkg::CALC_W-1:0] ORD_HI =
		ectmp_pkg::CALC_W'(ectmp_pkg::ORDER_HI);
	localparam logic signed [ectmp_pkg::CALC_W-1:0] ONE_X  = ectmp_pkg::CALC_W'(1);
	localparam logic signed [ectmp_pkg::CALC_W-1:0] ZERO_X = '0;

	logic [ectmp_pkg::MOD_W-1:0]         p_q;
	logic [ectmp_pkg::COEF_W-1:0]        ra_q;
	logic [ectmp_pkg::COEF_W-1:0]        rb_q;
	logic [ectmp_pkg::MOD_W-1:0]         a_q;
	logic [ectmp_pkg::MOD_W-1:0]         b_q;
	logic [ectmp_pkg::MOD_W-1:0]         t_q;
	logic [ectmp_pkg::MOD_W-1:0]         u_q;
	logic [ectmp_pkg::MOD_W-1:0]         x_q;
	logic [ectmp_pkg::MOD_W-1:0]         acc_q;
	logic [ectmp_pkg::MOD_W-1:0]         base_q;
	logic [ectmp_pkg::MOD_W-1:0]         e_q;
	logic                                fz_q;
	logic                                ns_q;
	logic signed [ectmp_pkg::SUM_W-1:0]  sum_q;
	logic                                out_valid_q;
	ectmp_pkg::out_item_t                out_q;

	logic [ectmp_pkg::OP_W-1:0]          op1;
	logic [ectmp_pkg::MOD_W-1:0]         op2;
	logic                                mm_done;
	logic [ectmp_pkg::MOD_W-1:0]         mm_res;

	logic [ectmp_pkg::MOD_W:0]           s1;
	logic [ectmp_pkg::MOD_W:0]           s1m;
	logic [ectmp_pkg::MOD_W:0]           s2;
	logic [ectmp_pkg::MOD_W:0]           s2m;
	logic [ectmp_pkg::MOD_W:0]           p_e;
	logic [ectmp_pkg::MOD_W-1:0]         f_val;
	logic [ectmp_pkg::MOD_W-1:0]         half;

	logic signed [ectmp_pkg::CALC_W-1:0] sum_x;
	logic signed [ectmp_pkg::CALC_W-1:0] tr_full;
	logic signed [ectmp_pkg::CALC_W-1:0] tr_sat;
	logic signed [ectmp_pkg::CALC_W-1:0] p_x;
	logic signed [ectmp_pkg::CALC_W-1:0] ord_full;
	logic signed [ectmp_pkg::CALC_W-1:0] ord_sat;

	always_comb begin
		op1 = '0;
		op2 = '0;
		case (cmd.mul_op)
			ectmp_pkg::OP_RED_A: begin
				op1 = ectmp_pkg::OP_W'(ra_q);
				op2 = ectmp_pkg::ONE;
			end
			ectmp_pkg::OP_RED_B: begin
				op1 = ectmp_pkg::OP_W'(rb_q);
				op2 = ectmp_pkg::ONE;
			end
			ectmp_pkg::OP_A2: begin
				op1 = ectmp_pkg::OP_W'(a_q);
				op2 = a_q;
			end
			ectmp_pkg::OP_A3: begin
				op1 = ectmp_pkg::OP_W'(t_q);
				op2 = a_q;
			end
			ectmp_pkg::OP_A4: begin
				op1 = ectmp_pkg::K_FOUR;
				op2 = t_q;
			end
			ectmp_pkg::OP_B2: begin
				op1 = ectmp_pkg::OP_W'(b_q);
				op2 = b_q;
			end
			ectmp_pkg::OP_B27: begin
				op1 = ectmp_pkg::K_TWENTYSEVEN;
				op2 = u_q;
			end
			ectmp_pkg::OP_X2: begin
				op1 = ectmp_pkg::OP_W'(x_q);
				op2 = x_q;
			end
			ectmp_pkg::OP_X3: begin
				op1 = ectmp_pkg::OP_W'(t_q);
				op2 = x_q;
			end
			ectmp_pkg::OP_AX: begin
				op1 = ectmp_pkg::OP_W'(a_q);
				op2 = x_q;
			end
			ectmp_pkg::OP_PMUL: begin
				op1 = ectmp_pkg::OP_W'(acc_q);
				op2 = base_q;
			end
			ectmp_pkg::OP_PSQ: begin
				op1 = ectmp_pkg::OP_W'(base_q);
				op2 = base_q;
			end
			default: begin
				op1 = '0;
				op2 = '0;
			end
		endcase
	end

	ectmp_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.op1    (op1),
		.op2    (op2),
		.p      (p_q),
		.done   (mm_done),
		.res    (mm_res)
	);

	always_comb begin
		p_e   = {1'b0, p_q};
		s1    = {1'b0, t_q} + {1'b0, u_q};
		s1m   = (s1 >= p_e) ? (s1 - p_e) : s1;
		s2    = {1'b0, s1m[ectmp_pkg::MOD_W-1:0]} + {1'b0, b_q};
		s2m   = (s2 >= p_e) ? (s2 - p_e) : s2;
		f_val = s2m[ectmp_pkg::MOD_W-1:0];
		half  = (p_q - ectmp_pkg::ONE) >> 1;
	end

	always_comb begin
		sum_x    = {{(ectmp_pkg::CALC_W-ectmp_pkg::SUM_W){sum_q[ectmp_pkg::SUM_W-1]}}, sum_q};
		tr_full  = -sum_x;
		if (tr_full > TR_HI) begin
			tr_sat = TR_HI;
		end else if (tr_full < TR_LO) begin
			tr_sat = TR_LO;
		end else begin
			tr_sat = tr_full;
		end
		p_x      = {{(ectmp_pkg::CALC_W-ectmp_pkg::MOD_W){1'b0}}, p_q};
		ord_full = p_x + ONE_X - tr_sat;
		if (ord_full < ZERO_X) begin
			ord_sat = ZERO_X;
		end else if (ord_full > ORD_HI) begin
			ord_sat = ORD_HI;
		end else begin
			ord_sat = ord_full;
		end
	end

	always_comb begin
		st.mul_done  = mm_done;
		st.low_mod   = p_q < ectmp_pkg::MIN_MODULUS;
		st.disc_zero = (s1 == '0) || (s1 == p_e);
		st.f_zero    = fz_q;
		st.e_lsb     = e_q[0];
		st.e_last    = (e_q >> 1) == '0;
		st.x_last    = x_q == (p_q - ectmp_pkg::ONE);
		st.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q         <= ectmp_pkg::MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				p_q <= cfg_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			ra_q <= in_data.coef_a;
			rb_q <= in_data.coef_b;
		end
		if (cmd.mul_wr) begin
			case (cmd.mul_op)
				ectmp_pkg::OP_RED_A: a_q    <= mm_res;
				ectmp_pkg::OP_RED_B: b_q    <= mm_res;
				ectmp_pkg::OP_A2:    t_q    <= mm_res;
				ectmp_pkg::OP_A3:    t_q    <= mm_res;
				ectmp_pkg::OP_A4:    t_q    <= mm_res;
				ectmp_pkg::OP_B2:    u_q    <= mm_res;
				ectmp_pkg::OP_B27:   u_q    <= mm_res;
				ectmp_pkg::OP_X2:    t_q    <= mm_res;
				ectmp_pkg::OP_X3:    t_q    <= mm_res;
				ectmp_pkg::OP_AX:    u_q    <= mm_res;
				ectmp_pkg::OP_PMUL:  acc_q  <= mm_res;
				ectmp_pkg::OP_PSQ: begin
					base_q <= mm_res;
					e_q    <= e_q >> 1;
				end
				default: ;
			endcase
		end
		if (cmd.set_sing) begin
			ns_q  <= 1'b0;
			sum_q <= '0;
		end
		if (cmd.init_loop) begin
			ns_q  <= 1'b1;
			sum_q <= '0;
			x_q   <= '0;
		end
		if (cmd.form_f) begin
			base_q <= f_val;
			fz_q   <= f_val == '0;
			acc_q  <= ectmp_pkg::ONE;
			e_q    <= half;
		end
		if (cmd.step_x) begin
			x_q <= x_q + ectmp_pkg::ONE;
			if (!fz_q) begin
				sum_q <= (acc_q == ectmp_pkg::ONE) ? (sum_q + ectmp_pkg::SUM_W'(1))
								  : (sum_q - ectmp_pkg::SUM_W'(1));
			end
		end
		if (cmd.out_load) begin
			out_q.nonsingular <= ns_q;
			out_q.trace       <= ns_q ? tr_sat[ectmp_pkg::TRACE_W-1:0] : '0;
			out_q.curve_order <= ns_q ? ord_sat[ectmp_pkg::ORDER_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/ectmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ectmp_ctrl
// Sequencer: coefficient reduction, discriminant, residue loop and
// square-and-multiply exponentiation on the shared multiplier.
// ----------------------------------------------------------------------------
`include "elliptic_curve_trace_mod_prime_defines.svh"

module ectmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ectmp_pkg::dp_stat_t st,
	output ectmp_pkg::dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_RED_A = 17'h00002,
		S_RED_B = 17'h00004,
		S_A2    = 17'h00008,
		S_A3    = 17'h00010,
		S_A4    = 17'h00020,
		S_B2    = 17'h00040,
		S_B27   = 17'h00080,
		S_DISC  = 17'h00100,
		S_X2    = 17'h00200,
		S_X3    = 17'h00400,
		S_AX    = 17'h00800,
		S_F     = 17'h01000,
		S_PMUL  = 17'h02000,
		S_PSQ   = 17'h04000,
		S_NEXT  = 17'h08000,
		S_DONE  = 17'h10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   started_q;
	logic   run;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.mul_op = ectmp_pkg::OP_RED_A;
		run        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					if (st.low_mod) begin
						cmd.set_sing = 1'b1;
						state_d      = S_DONE;
					end else begin
						state_d = S_RED_A;
					end
				end
			end
			S_RED_A: begin
				cmd.mul_op = ectmp_pkg::OP_RED_A;
				run        = 1'b1;
				if (st.mul_done) state_d = S_RED_B;
			end
			S_RED_B: begin
				cmd.mul_op = ectmp_pkg::OP_RED_B;
				run        = 1'b1;
				if (st.mul_done) state_d = S_A2;
			end
			S_A2: begin
				cmd.mul_op = ectmp_pkg::OP_A2;
				run        = 1'b1;
				if (st.mul_done) state_d = S_A3;
			end
			S_A3: begin
				cmd.mul_op = ectmp_pkg::OP_A3;
				run        = 1'b1;
				if (st.mul_done) state_d = S_A4;
			end
			S_A4: begin
				cmd.mul_op = ectmp_pkg::OP_A4;
				run        = 1'b1;
				if (st.mul_done) state_d = S_B2;
			end
			S_B2: begin
				cmd.mul_op = ectmp_pkg::OP_B2;
				run        = 1'b1;
				if (st.mul_done) state_d = S_B27;
			end
			S_B27: begin
				cmd.mul_op = ectmp_pkg::OP_B27;
				run        = 1'b1;
				if (st.mul_done) state_d = S_DISC;
			end
			S_DISC: begin
				if (st.disc_zero) begin
					cmd.set_sing = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.init_loop = 1'b1;
					state_d       = S_X2;
				end
			end
			S_X2: begin
				cmd.mul_op = ectmp_pkg::OP_X2;
				run        = 1'b1;
				if (st.mul_done) state_d = S_X3;
			end
			S_X3: begin
				cmd.mul_op = ectmp_pkg::OP_X3;
				run        = 1'b1;
				if (st.mul_done) state_d = S_AX;
			end
			S_AX: begin
				cmd.mul_op = ectmp_pkg::OP_AX;
				run        = 1'b1;
				if (st.mul_done) state_d = S_F;
			end
			S_F: begin
				cmd.form_f = 1'b1;
				state_d    = S_PMUL;
			end
			S_PMUL: begin
				cmd.mul_op = ectmp_pkg::OP_PMUL;
				if (st.f_zero) begin
					state_d = S_NEXT;
				end else if (!st.e_lsb) begin
					state_d = S_PSQ;
				end else begin
					run = 1'b1;
					if (st.mul_done) state_d = st.e_last ? S_NEXT : S_PSQ;
				end
			end
			S_PSQ: begin
				cmd.mul_op = ectmp_pkg::OP_PSQ;
				run        = 1'b1;
				if (st.mul_done) state_d = S_PMUL;
			end
			S_NEXT: begin
				cmd.step_x = 1'b1;
				state_d    = st.x_last ? S_DONE : S_X2;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.mul_start = run && !started_q;
		cmd.mul_wr    = run && st.mul_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_start) begin
				started_q <= 1'b1;
			end else if (cmd.mul_wr) begin
				started_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

	`ECTMP_ASSERT_IMP(a_ctl_out_free, cmd.out_load, st.out_free, "result loaded into occupied output register")
	`ECTMP_ASSERT_NXT(a_ctl_start_pulse, cmd.mul_start, !cmd.mul_start, "multiplier start held longer than one cycle")
	`ECTMP_ASSERT_IMP(a_ctl_done_owned, st.mul_done, started_q, "multiplier done without a pending operation")

endmodule

@@ hdl/elliptic_curve_trace_mod_prime.sv @@
// ----------------------------------------------------------------------------
// elliptic_curve_trace_mod_prime
// Point count of y^2 = x^3 + ax + b over a configured prime: trace and order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Beat
// cfg       in         cfg_valid/cfg_ready   modulus
// in        in         in_valid/in_stall     coef_a, coef_b
// out       out        out_valid/out_stall   nonsingular, trace, curve_order
//
// One item at a time. Every modular product runs on one bit-serial multiplier.
// A nonsingular curve takes about p * (3 + k) products, k the products of one
// exponentiation (up to 2 * log2(p)); a singular one about 7; p below 3 none.
// Reset loads modulus 601. A stalled result stays in the output register while
// the next item is accepted; the item then holds in its last step.
// ----------------------------------------------------------------------------
module elliptic_curve_trace_mod_prime (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ectmp_pkg::MOD_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ectmp_pkg::in_item_t         in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ectmp_pkg::out_item_t        out_data
);

	ectmp_pkg::dp_cmd_t  cmd;
	ectmp_pkg::dp_stat_t st;
	logic                cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	ectmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ectmp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Curve point-count regression: directed and random coefficient beats over a
// range of moduli, every result checked against an in-bench count.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	class curve_tally;
		logic [ectmp_pkg::MOD_W-1:0] modulus;
		ectmp_pkg::out_item_t        pending_counts[$];
		int                          fails;

		function new();
			modulus = ectmp_pkg::MODULUS_RESET;
			fails = 0;
		endfunction

		function void set_modulus(logic [ectmp_pkg::MOD_W-1:0] v);
			modulus = v;
		endfunction

		function longint unsigned pow_mod(longint unsigned base, longint unsigned e,
			longint unsigned p);
			longint unsigned acc;
			acc = 1 % p;
			base = base % p;
			while (e != 0) begin
				if (e[0])
					acc = acc * base % p;
				base = base * base % p;
				e = e >> 1;
			end
			return acc;
		endfunction

		function ectmp_pkg::out_item_t count_curve(ectmp_pkg::in_item_t it);
			longint unsigned      p, a, b, disc, half, f;
			int                   sum, tr, ord;
			ectmp_pkg::out_item_t r;
			r = '0;
			sum = 0;
			p = 64'(modulus);
			if (p < 3)
				return r;
			a = 64'(it.coef_a) % p;
			b = 64'(it.coef_b) % p;
			disc = (4 * (a * a % p * a % p) + 27 * (b * b % p)) % p;
			if (disc == 0)
				return r;
			half = (p - 1) / 2;
			for (longint unsigned x = 0; x < p; x++) begin
				f = (x * x % p * x % p + a * x % p + b) % p;
				if (f == 0)
					continue;
				if (pow_mod(f, half, p) == 1)
					sum++;
				else
					sum--;
			end
			tr = -sum;
			if (tr > ectmp_pkg::TRACE_HI)
				tr = ectmp_pkg::TRACE_HI;
			if (tr < ectmp_pkg::TRACE_LO)
				tr = ectmp_pkg::TRACE_LO;
			ord = int'(p) + 1 - tr;
			if (ord < 0)
				ord = 0;
			if (ord > ectmp_pkg::ORDER_HI)
				ord = ectmp_pkg::ORDER_HI;
			r.nonsingular = 1'b1;
			r.trace = tr[ectmp_pkg::TRACE_W-1:0];
			r.curve_order = ord[ectmp_pkg::ORDER_W-1:0];
			return r;
		endfunction

		function void note_coefs(ectmp_pkg::in_item_t it);
			pending_counts.insert(pending_counts.size(), count_curve(it));
		endfunction

		function int pending();
			return pending_counts.size();
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			fails++;
		endtask

		task check_count(ectmp_pkg::out_item_t got);
			ectmp_pkg::out_item_t want;
			if (pending_counts.size() == 0) begin
				report($sformatf("unexpected beat ns=%0b tr=%0d ord=%0d",
					got.nonsingular, got.trace, got.curve_order));
				return;
			end
			want = pending_counts.pop_front();
			if (got.nonsingular !== want.nonsingular)
				report($sformatf("nonsingular %0b, want %0b", got.nonsingular,
					want.nonsingular));
			if (got.trace !== want.trace)
				report($sformatf("trace %0d, want %0d", got.trace, want.trace));
			if (got.curve_order !== want.curve_order)
				report($sformatf("curve_order %0d, want %0d", got.curve_order,
					want.curve_order));
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [ectmp_pkg::MOD_W-1:0] cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	ectmp_pkg::in_item_t         in_data = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	ectmp_pkg::out_item_t        out_data;

	logic                        out_hold = 1'b0;
	bit                          idle_on = 1'b1;
	int                          stall_left = 0;
	curve_tally                  tally;

	int unsigned small_mods[14] = '{0, 2, 5, 7, 9, 11, 13, 15, 17, 19, 23, 25, 29, 31};

	elliptic_curve_trace_mod_prime u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	task automatic write_modulus(input logic [ectmp_pkg::MOD_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tally.set_modulus(v);
	endtask

	task automatic send_coefs(input logic [ectmp_pkg::COEF_W-1:0] a,
		input logic [ectmp_pkg::COEF_W-1:0] b);
		ectmp_pkg::in_item_t it;
		it.coef_a = a;
		it.coef_b = b;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		tally.note_coefs(it);
	endtask

	task automatic send_random(input int unsigned p);
		logic [ectmp_pkg::COEF_W-1:0] a, b;
		if (p != 0 && $urandom_range(0, 1)) begin
			a = ectmp_pkg::COEF_W'($urandom_range(0, p - 1));
			b = ectmp_pkg::COEF_W'($urandom_range(0, p - 1));
		end else begin
			a = ectmp_pkg::COEF_W'($urandom_range(0, 1023));
			b = ectmp_pkg::COEF_W'($urandom_range(0, 1023));
		end
		send_coefs(a, b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tally.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tally.check_count(out_data);
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 10);
			out_stall <= out_hold || (stall_left != 0);
		end
	end

	initial begin
		#200ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned p;
		tally = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_coefs(0, 0);
		send_coefs(601, 601);
		send_coefs(1, 1);
		drain();

		write_modulus(1021);
		send_coefs(0, 0);
		send_coefs(1021, 1021);
		send_coefs(1020, 1020);
		drain();

		write_modulus(1023);
		send_coefs(0, 0);
		send_coefs(1023, 1023);
		drain();

		for (int m = 0; m < 3; m++) begin
			write_modulus(ectmp_pkg::MOD_W'(m));
			send_coefs(1023, 1023);
			send_random(0);
			drain();
		end

		write_modulus(3);
		send_coefs(0, 5);
		send_coefs(1, 0);
		send_coefs(2, 2);
		send_coefs(1023, 1023);
		drain();

		write_modulus(153);
		send_coefs(1, 1);
		send_coefs(0, 7);
		drain();

		write_modulus(9);
		send_coefs(3, 0);
		send_coefs(1, 1);
		drain();

		repeat (10) begin
			p = small_mods[$urandom_range(0, 13)];
			write_modulus(ectmp_pkg::MOD_W'(p));
			repeat (7) send_random(p);
			drain();
		end

		write_modulus(5);
		fork
			begin
				out_hold <= 1'b1;
				repeat (4000) @(posedge clk);
				out_hold <= 1'b0;
			end
			begin
				repeat (6) send_random(5);
			end
		join
		drain();

		idle_on = 1'b0;
		write_modulus(13);
		repeat (6) send_random(13);
		drain();

		if (tally.fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
